// ----- sv/lot_pkg.sv -----
`default_nettype none

package lot_pkg;

    localparam int DEF_MAX_LAYERS = 256;

    // widths of the stream payloads
    localparam int KIND_W = 2;
    localparam int IN_W   = 24;
    localparam int OUT_W  = 32;

    // operation codes carried in s_tuser
    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd2;

    // broadcast controls for the row of rank cells
    typedef struct packed {
        logic shift_en;
        logic from_lower;
        logic place_en;
        logic lane_load;
        logic lane_shift;
        logic toward_high;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/layer_order_table.sv -----
`default_nettype none

// Layer stack manager. Items arrive on s_*; s_tuser carries the operation (allocate,
// set height, free). Results leave on m_* from an output register, one per item.
// After reset a clearing pass sweeps the rank store; no item is taken during it. Set
// height and free go from an execute state to the done state when the stack is left
// as it is; when only the addressed layer moves, a final state places it unless it is
// being hidden. When layers shift, the row of rank cells reorders in the execute state,
// then a drain lane walks the moved entries out to the rank store one per cycle, and a
// final state places the moved layer unless it is being hidden. Allocate scans the used
// flags eight slots a cycle. The rank store has a single write port.
module layer_order_table #(
    parameter int MAX_LAYERS = lot_pkg::DEF_MAX_LAYERS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [lot_pkg::IN_W-1:0]    s_tdata,   // layer_id[7:0], requested_height[16:8]
    input  logic [lot_pkg::KIND_W-1:0]  s_tuser,   // kind[1:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [lot_pkg::OUT_W-1:0]   m_tdata    // ok[0], result_layer[8:1],
                                                   // applied_height[17:9], top_rank[26:18],
                                                   // repaint_needed[27]
);

    import lot_pkg::*;

    localparam int IDX_W  = $clog2(MAX_LAYERS);
    localparam int RANK_W = IDX_W + 1;
    localparam int CW     = ((RANK_W > 9) ? RANK_W : 9) + 1;
    localparam int CHUNK  = 8;
    localparam int NCHUNK = (MAX_LAYERS + CHUNK - 1) / CHUNK;
    localparam int CH_W   = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PAD_W  = NCHUNK * CHUNK;

    localparam logic signed [CW-1:0]     NEG1    = '1;
    localparam logic signed [CW-1:0]     ZERO    = '0;
    localparam logic signed [CW-1:0]     ONE     = CW'(1);
    localparam logic signed [CW-1:0]     TOP_MAX = CW'(MAX_LAYERS - 1);
    localparam logic signed [RANK_W-1:0] NEG1_R  = '1;
    localparam logic [IDX_W-1:0]         LAST_IDX = IDX_W'(MAX_LAYERS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DRAIN,
        S_FINAL,
        S_DONE
    } state_t;

    state_t                   state_reg;
    logic [KIND_W-1:0]        kind_reg;
    logic [7:0]               id8_reg;
    logic [IDX_W-1:0]         op_id_reg;
    logic                     id_ok_reg;
    logic signed [8:0]        req_reg;
    logic signed [RANK_W-1:0] top_reg;
    logic signed [RANK_W-1:0] applied_reg;
    logic signed [RANK_W-1:0] place_h_reg;
    logic                     rep_reg;
    logic                     ok_reg;
    logic [7:0]               rl_reg;
    logic                     final_reg;
    logic                     desc_reg;
    logic [IDX_W-1:0]         cnt_reg;
    logic [IDX_W-1:0]         end_reg;
    logic [CH_W-1:0]          chunk_reg;
    logic [MAX_LAYERS-1:0]    used_reg;
    logic                     m_tvalid_reg;
    logic [OUT_W-1:0]         m_tdata_reg;

    logic [7:0]               s_id;
    logic signed [8:0]        s_req;

    logic                     st_we;
    logic [IDX_W-1:0]         st_waddr;
    logic signed [RANK_W-1:0] st_wdata;
    logic signed [RANK_W-1:0] old_rank;
    logic                     st_ready;

    logic signed [CW-1:0]     old_e;
    logic signed [CW-1:0]     top_e;
    logic signed [CW-1:0]     h_c;
    logic signed [CW-1:0]     sh_lo_e;
    logic signed [CW-1:0]     sh_hi_e;
    logic                     do_move;
    logic                     ignore_show;
    logic                     mv_a;
    logic                     mv_b;
    logic                     mv_c;
    logic                     mv_d;
    logic                     mv_any;
    logic                     sh_any;

    cell_ctrl_t               cell_ctrl;
    logic [IDX_W-1:0]         cell_lo;
    logic [IDX_W-1:0]         cell_hi;
    logic [IDX_W-1:0]         cell_id_w   [MAX_LAYERS];
    logic                     lane_valid_w [MAX_LAYERS];
    logic [IDX_W-1:0]         lane_id_w   [MAX_LAYERS];
    logic                     em_valid;
    logic [IDX_W-1:0]         em_id;

    logic [PAD_W-1:0]         used_pad;
    logic [CHUNK-1:0]         chunk_bits;
    logic                     scan_found;
    logic [2:0]               scan_off;
    logic [CH_W+2:0]          slot_w;
    logic [IDX_W-1:0]         slot_idx;

    assign s_id  = s_tdata[7:0];
    assign s_req = s_tdata[16:8];

    lot_rank_store #(
        .MAX_LAYERS (MAX_LAYERS)
    ) u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (IDX_W'(s_id)),
        .rdata (old_rank),
        .ready (st_ready)
    );

    // move decision, valid in the execute cycle
    always_comb
    begin
        old_e = CW'(old_rank);
        top_e = CW'(top_reg);
        h_c   = (kind_reg == KIND_FREE) ? NEG1 : CW'(req_reg);
        if ((old_e >= ZERO) && (h_c > top_e))
        begin
            h_c = top_e;
        end
        if (h_c > top_e + ONE)
        begin
            h_c = top_e + ONE;
        end
        if (h_c < NEG1)
        begin
            h_c = NEG1;
        end
        do_move = id_ok_reg && ((kind_reg == KIND_SET) ||
                                ((kind_reg == KIND_FREE) && (old_e >= ZERO)));
        ignore_show = (old_e < ZERO) && (h_c >= ZERO) && (top_e == TOP_MAX);
        mv_a   = do_move && !ignore_show && (old_e > h_c) && (h_c >= ZERO);
        mv_b   = do_move && !ignore_show && (old_e > h_c) && (h_c < ZERO);
        mv_c   = do_move && !ignore_show && (old_e < h_c) && (old_e >= ZERO);
        mv_d   = do_move && !ignore_show && (old_e < h_c) && (old_e < ZERO);
        mv_any = mv_a || mv_b || mv_c || mv_d;

        sh_lo_e = h_c + ONE;
        sh_hi_e = old_e;
        sh_any  = 1'b1;
        if (mv_b)
        begin
            sh_lo_e = old_e;
            sh_hi_e = top_e - ONE;
            sh_any  = old_e < top_e;
        end
        else if (mv_c)
        begin
            sh_lo_e = old_e;
            sh_hi_e = h_c - ONE;
        end
        else if (mv_d)
        begin
            sh_hi_e = top_e + ONE;
            sh_any  = h_c <= top_e;
        end
    end

    assign cell_lo = IDX_W'(sh_lo_e);
    assign cell_hi = IDX_W'(sh_hi_e);

    always_comb
    begin
        cell_ctrl = '0;
        if (state_reg == S_EXEC)
        begin
            cell_ctrl.shift_en   = mv_any && sh_any;
            cell_ctrl.from_lower = mv_a || mv_d;
            cell_ctrl.place_en   = mv_a || mv_c || mv_d;
            cell_ctrl.lane_load  = 1'b1;
        end
        else if (state_reg == S_DRAIN)
        begin
            cell_ctrl.lane_shift  = 1'b1;
            cell_ctrl.toward_high = desc_reg;
        end
    end

    for (genvar k = 0; k < MAX_LAYERS; k++)
    begin : g_cell
        lot_rank_cell #(
            .MAX_LAYERS (MAX_LAYERS),
            .IDX        (k)
        ) u_cell (
            .clk              (clk),
            .rst_n            (rst_n),
            .ctrl             (cell_ctrl),
            .lo               (cell_lo),
            .hi               (cell_hi),
            .place_rank       (IDX_W'(h_c)),
            .place_id         (op_id_reg),
            .lower_id         (cell_id_w[(k == 0) ? 0 : k - 1]),
            .upper_id         (cell_id_w[(k == MAX_LAYERS - 1) ? k : k + 1]),
            .lower_lane_valid ((k != 0) && lane_valid_w[(k == 0) ? 0 : k - 1]),
            .lower_lane_id    (lane_id_w[(k == 0) ? 0 : k - 1]),
            .upper_lane_valid ((k != MAX_LAYERS - 1) &&
                               lane_valid_w[(k == MAX_LAYERS - 1) ? k : k + 1]),
            .upper_lane_id    (lane_id_w[(k == MAX_LAYERS - 1) ? k : k + 1]),
            .cell_id          (cell_id_w[k]),
            .lane_valid       (lane_valid_w[k]),
            .lane_id          (lane_id_w[k])
        );
    end

    // entry leaving the drain lane this cycle, rank given by cnt_reg
    assign em_valid = desc_reg ? lane_valid_w[MAX_LAYERS - 1] : lane_valid_w[0];
    assign em_id    = desc_reg ? lane_id_w[MAX_LAYERS - 1] : lane_id_w[0];

    // lowest free slot, eight slots per cycle, padding reads as used
    always_comb
    begin
        used_pad = '1;
        used_pad[MAX_LAYERS-1:0] = used_reg;
        chunk_bits = used_pad[chunk_reg * CHUNK +: CHUNK];
        scan_found = 1'b0;
        scan_off   = '0;
        for (int i = CHUNK - 1; i >= 0; i--)
        begin
            if (!chunk_bits[i])
            begin
                scan_found = 1'b1;
                scan_off   = 3'(i);
            end
        end
    end

    assign slot_w   = {chunk_reg, scan_off};
    assign slot_idx = IDX_W'(slot_w);

    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = op_id_reg;
        st_wdata = NEG1_R;
        if ((state_reg == S_EXEC) && mv_b)
        begin
            st_we = 1'b1;
        end
        else if ((state_reg == S_DRAIN) && em_valid)
        begin
            st_we    = 1'b1;
            st_waddr = em_id;
            st_wdata = signed'({1'b0, cnt_reg});
        end
        else if (state_reg == S_FINAL)
        begin
            st_we    = 1'b1;
            st_wdata = place_h_reg;
        end
        else if ((state_reg == S_SCAN) && scan_found)
        begin
            st_we    = 1'b1;
            st_waddr = slot_idx;
        end
    end

    assign s_tready = (state_reg == S_IDLE) && st_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            kind_reg     <= '0;
            id8_reg      <= '0;
            op_id_reg    <= '0;
            id_ok_reg    <= 1'b0;
            req_reg      <= '0;
            top_reg      <= NEG1_R;
            applied_reg  <= NEG1_R;
            place_h_reg  <= NEG1_R;
            rep_reg      <= 1'b0;
            ok_reg       <= 1'b0;
            rl_reg       <= '0;
            final_reg    <= 1'b0;
            desc_reg     <= 1'b0;
            cnt_reg      <= '0;
            end_reg      <= '0;
            chunk_reg    <= '0;
            used_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            // the done state loads the next result itself
            if (m_tvalid_reg && m_tready && (state_reg != S_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid && s_tready)
                    begin
                        kind_reg  <= s_tuser;
                        id8_reg   <= s_id;
                        op_id_reg <= IDX_W'(s_id);
                        id_ok_reg <= 32'(s_id) < 32'(MAX_LAYERS);
                        req_reg   <= s_req;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    priority if (kind_reg == KIND_ALLOC)
                    begin
                        rep_reg     <= 1'b0;
                        ok_reg      <= 1'b0;
                        rl_reg      <= '0;
                        applied_reg <= NEG1_R;
                        chunk_reg   <= '0;
                        state_reg   <= S_SCAN;
                    end
                    else if (!id_ok_reg)
                    begin
                        rep_reg     <= 1'b0;
                        ok_reg      <= 1'b1;
                        rl_reg      <= id8_reg;
                        applied_reg <= NEG1_R;
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        ok_reg <= 1'b1;
                        rl_reg <= id8_reg;
                        if (kind_reg == KIND_FREE)
                        begin
                            used_reg[op_id_reg] <= 1'b0;
                        end
                        if (mv_any)
                        begin
                            rep_reg     <= 1'b1;
                            applied_reg <= mv_b ? NEG1_R : RANK_W'(h_c);
                            place_h_reg <= RANK_W'(h_c);
                            final_reg   <= !mv_b;
                            if (mv_b && (top_e > NEG1))
                            begin
                                top_reg <= RANK_W'(top_e - ONE);
                            end
                            else if (mv_d)
                            begin
                                top_reg <= RANK_W'(top_e + ONE);
                            end
                            if (sh_any)
                            begin
                                desc_reg  <= mv_a || mv_d;
                                cnt_reg   <= (mv_a || mv_d) ? LAST_IDX : '0;
                                end_reg   <= (mv_a || mv_d) ? cell_lo : cell_hi;
                                state_reg <= S_DRAIN;
                            end
                            else
                            begin
                                state_reg <= mv_b ? S_DONE : S_FINAL;
                            end
                        end
                        else
                        begin
                            // unknown kinds and moves that change nothing
                            rep_reg     <= 1'b0;
                            applied_reg <= old_rank;
                            state_reg   <= S_DONE;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (scan_found)
                    begin
                        used_reg[slot_idx] <= 1'b1;
                        ok_reg             <= 1'b1;
                        rl_reg             <= 8'(slot_w);
                        state_reg          <= S_DONE;
                    end
                    else if (chunk_reg == CH_W'(NCHUNK - 1))
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        chunk_reg <= chunk_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    // a shifted copy of the addressed layer also rewrites its rank
                    if (em_valid && (em_id == op_id_reg))
                    begin
                        applied_reg <= signed'({1'b0, cnt_reg});
                    end
                    if (cnt_reg == end_reg)
                    begin
                        state_reg <= final_reg ? S_FINAL : S_DONE;
                    end
                    else
                    begin
                        cnt_reg <= desc_reg ? cnt_reg - 1'b1 : cnt_reg + 1'b1;
                    end
                end
                S_FINAL:
                begin
                    applied_reg <= place_h_reg;
                    state_reg   <= S_DONE;
                end
                S_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {4'd0, rep_reg, 9'(top_reg), 9'(applied_reg),
                                         rl_reg, ok_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_top_range: assert property (@(posedge clk) disable iff (!rst_n)
        (top_reg >= NEG1_R) && (CW'(top_reg) <= TOP_MAX))
        else $error("top rank out of range");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_DONE))
        else $error("result presented without a finished item");

    a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |->
            ((m_tdata[8:1] == 8'd0) && (m_tdata[17:9] == 9'h1FF) && !m_tdata[27]))
        else $error("failed allocate result carries a layer or repaint");

endmodule

`default_nettype wire

// ----- sv/lot_rank_cell.sv -----
`default_nettype none

module lot_rank_cell #(
    parameter int MAX_LAYERS = lot_pkg::DEF_MAX_LAYERS,
    parameter int IDX        = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  lot_pkg::cell_ctrl_t               ctrl,
    input  logic [$clog2(MAX_LAYERS)-1:0]     lo,
    input  logic [$clog2(MAX_LAYERS)-1:0]     hi,
    input  logic [$clog2(MAX_LAYERS)-1:0]     place_rank,
    input  logic [$clog2(MAX_LAYERS)-1:0]     place_id,
    input  logic [$clog2(MAX_LAYERS)-1:0]     lower_id,
    input  logic [$clog2(MAX_LAYERS)-1:0]     upper_id,
    input  logic                              lower_lane_valid,
    input  logic [$clog2(MAX_LAYERS)-1:0]     lower_lane_id,
    input  logic                              upper_lane_valid,
    input  logic [$clog2(MAX_LAYERS)-1:0]     upper_lane_id,
    output logic [$clog2(MAX_LAYERS)-1:0]     cell_id,
    output logic                              lane_valid,
    output logic [$clog2(MAX_LAYERS)-1:0]     lane_id
);

    import lot_pkg::*;

    localparam int IDX_W = $clog2(MAX_LAYERS);
    localparam logic [IDX_W-1:0] MY_RANK = IDX_W'(IDX);

    logic [IDX_W-1:0] id_reg;
    logic [IDX_W-1:0] id_next;
    logic             lane_valid_reg;
    logic [IDX_W-1:0] lane_id_reg;
    logic             in_range;

    assign in_range = (MY_RANK >= lo) && (MY_RANK <= hi);

    always_comb
    begin
        id_next = id_reg;
        priority if (ctrl.place_en && (MY_RANK == place_rank))
        begin
            id_next = place_id;
        end
        else if (ctrl.shift_en && in_range)
        begin
            id_next = ctrl.from_lower ? lower_id : upper_id;
        end
        else
        begin
            id_next = id_reg;
        end
    end

    // rank slot contents are undefined until written
    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    // drain lane: a copy of the moved entries that walks to one end of the row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_valid_reg <= 1'b0;
        end
        else if (ctrl.lane_load)
        begin
            lane_valid_reg <= ctrl.shift_en && in_range;
        end
        else if (ctrl.lane_shift)
        begin
            lane_valid_reg <= ctrl.toward_high ? lower_lane_valid : upper_lane_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.lane_load)
        begin
            lane_id_reg <= id_next;
        end
        else if (ctrl.lane_shift)
        begin
            lane_id_reg <= ctrl.toward_high ? lower_lane_id : upper_lane_id;
        end
    end

    assign cell_id    = id_reg;
    assign lane_valid = lane_valid_reg;
    assign lane_id    = lane_id_reg;

endmodule

`default_nettype wire

// ----- sv/lot_rank_store.sv -----
`default_nettype none

module lot_rank_store #(
    parameter int MAX_LAYERS = lot_pkg::DEF_MAX_LAYERS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 we,
    input  logic [$clog2(MAX_LAYERS)-1:0]        waddr,
    input  logic signed [$clog2(MAX_LAYERS):0]   wdata,
    input  logic [$clog2(MAX_LAYERS)-1:0]        raddr,
    output logic signed [$clog2(MAX_LAYERS):0]   rdata,
    output logic                                 ready
);

    import lot_pkg::*;

    localparam int IDX_W  = $clog2(MAX_LAYERS);
    localparam int RANK_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_LAYERS - 1);

    logic signed [RANK_W-1:0] mem [MAX_LAYERS];
    logic signed [RANK_W-1:0] rdata_reg;
    logic [IDX_W-1:0]         clr_idx_reg;
    logic                     clr_busy_reg;

    // after reset every layer slot is swept to hidden
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == LAST_IDX)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_idx_reg] <= '1;
        end
        else if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
    assign ready = !clr_busy_reg;

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

    import lot_pkg::*;

    localparam int LAYERS       = DEF_MAX_LAYERS;
    localparam int RANDOM_ITEMS = 2000;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int DRAIN_LIMIT  = 50_000;
    localparam int SETTLE       = LAYERS + 64;
    localparam int HOLD_CYCLES  = 500;

    // kind 3 has no meaning in the block, it must leave the stack alone
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

    // receiver stall patterns
    localparam int RX_OPEN   = 0;
    localparam int RX_COIN   = 1;
    localparam int RX_SPARSE = 2;
    localparam int RX_RHYTHM = 3;

    typedef struct packed {
        logic              ok;
        logic [7:0]        layer;
        logic signed [8:0] height;
        logic signed [8:0] top;
        logic              repaint;
    } layer_result_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [7:0]        id;
        logic signed [8:0] req;
        bit                typed;
        layer_result_t     want;
    } script_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_W-1:0]       s_tdata;   // layer_id[7:0], requested_height[16:8]
    logic [KIND_W-1:0]     s_tuser;   // kind[1:0]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_W-1:0]      m_tdata;   // ok[0], result_layer[8:1], applied_height[17:9],
                                      // top_rank[26:18], repaint_needed[27]

    // shadow of the layer stack
    logic [7:0]            stack_at [0:LAYERS-1];
    logic signed [8:0]     rank_of  [0:LAYERS-1];
    bit                    in_use   [0:LAYERS-1];
    int                    top_now;

    layer_result_t         pending_results [$];
    script_row_t           script [$];
    int                    mismatches = 0;
    int                    burst_left = 0;
    int                    holds_asked = 0;

    layer_order_table #(
        .MAX_LAYERS (LAYERS)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic void seat(input int h, input logic [7:0] id);
        stack_at[h] = id;
        rank_of[id] = h[8:0];
    endfunction

    // move one layer to a new rank, shifting the ones in between; 1 if it moved
    function automatic bit restack(input logic [7:0] id, input int want);
        int was;
        int h;
        was = rank_of[id];
        if (was >= 0 && want > top_now)
            want = top_now;
        if (want > top_now + 1)
            want = top_now + 1;
        if (want < -1)
            want = -1;
        // full stack cannot take one more shown layer
        if (was < 0 && want >= 0 && top_now >= LAYERS - 1)
            return 1'b0;
        if (was == want)
            return 1'b0;
        rank_of[id] = want[8:0];
        if (was > want)
        begin
            if (want >= 0)
            begin
                for (h = was; h > want; h--)
                    seat(h, stack_at[h-1]);
                seat(want, id);
            end
            else
            begin
                for (h = was; h < top_now; h++)
                    seat(h, stack_at[h+1]);
                if (top_now > -1)
                    top_now--;
            end
        end
        else
        begin
            if (was >= 0)
            begin
                for (h = was; h < want; h++)
                    seat(h, stack_at[h+1]);
                seat(want, id);
            end
            else
            begin
                for (h = top_now; h >= want; h--)
                    seat(h + 1, stack_at[h]);
                seat(want, id);
                top_now++;
            end
        end
        return 1'b1;
    endfunction

    function automatic layer_result_t stack_op(input logic [KIND_W-1:0] kind,
                                               input logic [7:0] id,
                                               input logic signed [8:0] req);
        layer_result_t r;
        int i;
        bit found;
        r.ok = 1'b1;
        r.layer = id;
        r.height = -9'sd1;
        r.repaint = 1'b0;
        found = 1'b0;
        if (kind == KIND_ALLOC)
        begin
            r.ok = 1'b0;
            r.layer = 8'd0;
            for (i = 0; i < LAYERS && !found; i++)
            begin
                if (!in_use[i])
                begin
                    in_use[i] = 1'b1;
                    rank_of[i] = -9'sd1;
                    r.ok = 1'b1;
                    r.layer = i[7:0];
                    found = 1'b1;
                end
            end
        end
        else
        begin
            if (kind == KIND_SET)
                r.repaint = restack(id, req);
            else if (kind == KIND_FREE)
            begin
                if (rank_of[id] >= 0)
                    r.repaint = restack(id, -1);
                in_use[id] = 1'b0;
            end
            r.height = rank_of[id];
        end
        r.top = top_now[8:0];
        return r;
    endfunction

    task automatic add_step(input logic [KIND_W-1:0] kind, input int id, input int req,
                            input bit typed, input int ok, input int layer,
                            input int height, input int top, input int rep);
        script_row_t row;
        row.kind = kind;
        row.id = id[7:0];
        row.req = req[8:0];
        row.typed = typed;
        row.want.ok = ok[0];
        row.want.layer = layer[7:0];
        row.want.height = height[8:0];
        row.want.top = top[8:0];
        row.want.repaint = rep[0];
        script.push_back(row);
    endtask

    // present one item, wait for its handshake, then maybe leave a gap
    task automatic offer(input logic [KIND_W-1:0] kind, input logic [7:0] id,
                         input logic signed [8:0] req, input bit typed,
                         input layer_result_t want);
        layer_result_t predicted;
        int gap;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {{(IN_W-17){1'b0}}, req, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = stack_op(kind, id, req);
        pending_results.push_back(typed ? want : predicted);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 23);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // receiver with its own stall pattern and an occasional long hold-off
    initial
    begin
        int mode;
        int hold_left;
        int holds_done;
        int cyc;
        mode = RX_OPEN;
        hold_left = 0;
        holds_done = 0;
        cyc = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (cyc % 50 == 0)
                mode = $urandom_range(RX_OPEN, RX_RHYTHM);
            if (holds_done != holds_asked)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_OPEN:   m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_tready <= (cyc % 3 != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        layer_result_t seen;
        layer_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            seen.ok = m_tdata[0];
            seen.layer = m_tdata[8:1];
            seen.height = m_tdata[17:9];
            seen.top = m_tdata[26:18];
            seen.repaint = m_tdata[27];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: ok=%0d layer=%0d height=%0d top=%0d %s%0d",
                             seen.ok, seen.layer, seen.height, seen.top, "repaint=",
                             seen.repaint);
            end
            else
            begin
                want = pending_results.pop_front();
                if (seen.ok !== want.ok || seen.layer !== want.layer
                    || seen.height !== want.height || seen.top !== want.top
                    || seen.repaint !== want.repaint)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: expected ok=%0d layer=%0d height=%0d %s%0d %s%0d",
                                 want.ok, want.layer, want.height, "top=", want.top,
                                 "repaint=", want.repaint);
                        $display("          got      ok=%0d layer=%0d height=%0d %s%0d %s%0d",
                                 seen.ok, seen.layer, seen.height, "top=", seen.top,
                                 "repaint=", seen.repaint);
                    end
                end
            end
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        layer_result_t blank;
        logic [KIND_W-1:0] kind;
        logic [7:0] id;
        logic signed [8:0] req;
        int n;
        int i;
        int r;
        int v;
        int tries;
        int alloc_pct;
        int free_pct;
        int none_pct;
        int hide_pct;
        int drain;

        blank = '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= KIND_ALLOC;
        for (i = 0; i < LAYERS; i++)
        begin
            stack_at[i] = 8'd0;
            rank_of[i] = -9'sd1;
            in_use[i] = 1'b0;
        end
        top_now = -1;

        // after reset, extremes, clamping, hiding and showing, unused slots
        add_step(KIND_ALLOC, 0,    0,    1, 1, 0,   -1, -1, 0);
        add_step(KIND_ALLOC, 255,  255,  1, 1, 1,   -1, -1, 0);
        add_step(KIND_ALLOC, 7,    -256, 1, 1, 2,   -1, -1, 0);
        add_step(KIND_SET,   0,    255,  1, 1, 0,   0,  0,  1);
        add_step(KIND_SET,   1,    -256, 1, 1, 1,   -1, 0,  0);
        add_step(KIND_SET,   1,    0,    0, 0, 0,   0,  0,  0);
        add_step(KIND_SET,   2,    100,  0, 0, 0,   0,  0,  0);
        add_step(KIND_SET,   2,    255,  0, 0, 0,   0,  0,  0);
        add_step(KIND_SET,   2,    0,    0, 0, 0,   0,  0,  0);
        add_step(KIND_SET,   2,    2,    0, 0, 0,   0,  0,  0);
        add_step(KIND_NONE,  0,    0,    0, 0, 0,   0,  0,  0);
        add_step(KIND_FREE,  1,    5,    0, 0, 0,   0,  0,  0);
        add_step(KIND_FREE,  1,    -1,   0, 0, 0,   0,  0,  0);
        add_step(KIND_SET,   200,  1,    0, 0, 0,   0,  0,  0);
        add_step(KIND_ALLOC, 0,    0,    0, 0, 0,   0,  0,  0);
        add_step(KIND_SET,   255,  -1,   0, 0, 0,   0,  0,  0);
        add_step(KIND_FREE,  200,  0,    0, 0, 0,   0,  0,  0);
        add_step(KIND_NONE,  255,  -1,   0, 0, 0,   0,  0,  0);
        add_step(KIND_SET,   0,    -1,   0, 0, 0,   0,  0,  0);
        add_step(KIND_SET,   0,    -2,   0, 0, 0,   0,  0,  0);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            offer(script[i].kind, script[i].id, script[i].req, script[i].typed,
                  script[i].want);

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 700)
                holds_asked++;
            // let the block drain completely once
            if (n == 1200 && pending_results.size() != 0)
            begin
                s_tvalid <= 1'b0;
                while (pending_results.size() != 0)
                    @(posedge clk);
            end
            // build up, crowd the stack to full, churn, build again
            case (n / 500)
                0:
                begin
                    alloc_pct = 40; free_pct = 6;  none_pct = 4; hide_pct = 20;
                end
                1:
                begin
                    alloc_pct = 10; free_pct = 3;  none_pct = 2; hide_pct = 4;
                end
                2:
                begin
                    alloc_pct = 20; free_pct = 30; none_pct = 5; hide_pct = 30;
                end
                default:
                begin
                    alloc_pct = 30; free_pct = 10; none_pct = 5; hide_pct = 20;
                end
            endcase
            r = $urandom_range(0, 99);
            if (r < alloc_pct)
                kind = KIND_ALLOC;
            else if (r < alloc_pct + free_pct)
                kind = KIND_FREE;
            else if (r < alloc_pct + free_pct + none_pct)
                kind = KIND_NONE;
            else
                kind = KIND_SET;

            // mostly address slots that are in use
            id = 8'($urandom_range(0, 255));
            tries = 0;
            if ($urandom_range(0, 9) < 8)
            begin
                while (!in_use[id] && tries < 8)
                begin
                    id = 8'($urandom_range(0, 255));
                    tries++;
                end
            end

            r = $urandom_range(0, 99);
            if (r < hide_pct)
                req = ($urandom_range(0, 3) == 0) ? {1'b1, 8'($urandom)} : -9'sd1;
            else if (r < hide_pct + 15)
                req = 9'($urandom);
            else
            begin
                v = $urandom_range(0, top_now + 2);
                if (v > 255)
                    v = 255;
                req = v[8:0];
            end

            offer(kind, id, req, 1'b0, blank);
        end

        s_tvalid <= 1'b0;
        drain = 0;
        while (pending_results.size() != 0 && drain < DRAIN_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        if (pending_results.size() != 0)
            mismatches++;
        repeat (SETTLE) @(posedge clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
